/* hdl/ffha_pkg.sv */
// Shared types, constants and a helper function for the first-fit heap allocator.
// Depends on nothing; ffha_ctrl, the top level and the testbench import it.
package ffha_pkg;

  localparam int HEAP_BYTES  = 1048576;
  localparam int PAGE_BYTES  = 4096;
  localparam int GRAN_BYTES  = 8;
  localparam int HDR_DEPTH   = HEAP_BYTES / GRAN_BYTES;
  localparam int IDX_W       = $clog2(HDR_DEPTH);
  localparam int SZ_W        = $clog2(HDR_DEPTH + 1);
  localparam int MAX_PAGES   = HEAP_BYTES / PAGE_BYTES;
  localparam int PG_W        = $clog2(MAX_PAGES + 1);
  localparam int PAGE_GR     = PAGE_BYTES / GRAN_BYTES;
  localparam int PAGE_SH     = $clog2(PAGE_GR);
  localparam int PAGE_BSH    = $clog2(PAGE_BYTES);
  localparam int START_PAGES = 32'h10000 / PAGE_BYTES;
  localparam int START_GR    = 32'h10000 / GRAN_BYTES;
  localparam int REQ_W       = 24;
  localparam int ADDR_W      = 26;
  localparam int CFG_W       = 9;
  localparam int NEED_W      = REQ_W - 2;
  localparam int PGS_W       = NEED_W + 1 - PAGE_SH;
  localparam int HDR_LEN     = 16;
  localparam int SPLIT_GR    = 3;
  localparam logic [ADDR_W-1:0] ORIGIN = 26'h2000000;
  localparam logic [CFG_W-1:0]  LIMIT_RESET = 9'd256;

  typedef struct packed {
    logic [SZ_W-1:0]  size;
    logic             is_free;
    logic             taken;
    logic             has_next;
    logic             has_prev;
    logic [IDX_W-1:0] next;
    logic [IDX_W-1:0] prev;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_IGNORED = 2'd1,
    RS_NOMEM   = 2'd2,
    RS_BADFREE = 2'd3
  } res_status_t;

  typedef struct packed {
    logic              mode;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_address;
    res_status_t       status;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    hdr_t             wdata;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_A_START, S_A_RDH, S_A_WALK, S_A_GROW, S_A_CLAIM, S_A_CL2, S_A_CL3,
    S_A_CL4, S_F_START, S_F_HDR, S_F_WALK, S_F_NX, S_F_NXD, S_F_PV, S_F_PVD,
    S_F_WH, S_PT_RD, S_PT_WR, S_DONE
  } state_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] g);
    addr_of = ORIGIN + (ADDR_W'(g) << 3) + ADDR_W'(HDR_LEN);
  endfunction

endpackage

/* hdl/ffha_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/ffha_ctrl.sv */
// Request sequencer: list walks, splits, growth and coalescing on header memory.
// Depends on ffha_pkg; drives the header RAM instanced in the top level.
module ffha_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ffha_pkg::in_item_t         req,
  input  logic [ffha_pkg::CFG_W-1:0] page_limit,
  input  logic                       res_take,
  output ffha_pkg::ctrl_stat_t       stat,
  output ffha_pkg::out_item_t        res,
  output ffha_pkg::mem_req_t         mem_req,
  input  ffha_pkg::hdr_t             mem_rdata
);
  import ffha_pkg::*;

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  in_item_t          req_r, req_nxt;
  out_item_t         res_r, res_nxt;
  hdr_t              h_r, h_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt, g_r, g_nxt, ng_r, ng_nxt, head_r, head_nxt;
  logic [IDX_W-1:0]  pa_r, pa_nxt, pv_r, pv_nxt;
  logic              pprev_r, pprev_nxt, ph_r, ph_nxt;
  logic              empty_r, empty_nxt, ready_r, ready_nxt, split_r, split_nxt;
  logic [PG_W-1:0]   committed_r, committed_nxt;
  logic [NEED_W-1:0] needg_r, needg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      head_r      <= '0;
      empty_r     <= 1'b1;
      ready_r     <= 1'b0;
      committed_r <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      ready_r     <= ready_nxt;
      committed_r <= committed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    h_r     <= h_nxt;
    cur_r   <= cur_nxt;
    g_r     <= g_nxt;
    ng_r    <= ng_nxt;
    pa_r    <= pa_nxt;
    pv_r    <= pv_nxt;
    pprev_r <= pprev_nxt;
    ph_r    <= ph_nxt;
    split_r <= split_nxt;
    needg_r <= needg_nxt;
  end

  always_comb begin
    logic [REQ_W-1:0]   size_eff;
    logic [PGS_W-1:0]   pages;
    logic [PGS_W:0]     total;
    logic               init_ok, grow_ok, split;
    logic [IDX_W-1:0]   gnew, rnext;
    logic [SZ_W-1:0]    ext;
    logic [ADDR_W-1:0]  off;
    logic               rhas;
    hdr_t               w;
    logic               do_patch, pt_prev, pt_has;
    logic [IDX_W-1:0]   pt_addr, pt_val;
    state_t             pt_ret;

    state_nxt     = state_r;
    ret_nxt       = ret_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    h_nxt         = h_r;
    cur_nxt       = cur_r;
    g_nxt         = g_r;
    ng_nxt        = ng_r;
    head_nxt      = head_r;
    empty_nxt     = empty_r;
    ready_nxt     = ready_r;
    committed_nxt = committed_r;
    needg_nxt     = needg_r;
    split_nxt     = split_r;
    pa_nxt        = pa_r;
    pv_nxt        = pv_r;
    pprev_nxt     = pprev_r;
    ph_nxt        = ph_r;
    mem_req       = '0;
    mem_req.addr  = cur_r;
    do_patch      = 1'b0;
    pt_prev       = 1'b0;
    pt_has        = 1'b0;
    pt_addr       = '0;
    pt_val        = '0;
    pt_ret        = S_DONE;
    w             = '0;

    size_eff = (req_r.request_size < REQ_W'(8)) ? REQ_W'(8) : req_r.request_size;
    init_ok  = !ready_r && (page_limit >= CFG_W'(START_PAGES))
               && (START_PAGES <= MAX_PAGES);
    pages    = PGS_W'(((NEED_W+1)'(needg_r) + (NEED_W+1)'(PAGE_GR - 1)) >> PAGE_SH);
    total    = (PGS_W+1)'(committed_r) + (PGS_W+1)'(pages);
    grow_ok  = (total <= (PGS_W+1)'(page_limit)) && (total <= (PGS_W+1)'(MAX_PAGES));
    gnew     = IDX_W'(committed_r) << PAGE_SH;
    ext      = SZ_W'(pages) << PAGE_SH;
    split    = (NEED_W+1)'(h_r.size) >= ((NEED_W+1)'(needg_r) + (NEED_W+1)'(SPLIT_GR));
    off      = req_r.free_address - (ORIGIN + ADDR_W'(HDR_LEN));
    rnext    = split_r ? ng_r : h_r.next;
    rhas     = split_r | h_r.has_next;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = req;
          state_nxt = req.mode ? S_F_START : S_A_START;
        end
      end

      // Lazy start, size screening and granule count of the request.
      S_A_START: begin
        if (init_ok) begin
          w.size        = SZ_W'(START_GR);
          w.is_free     = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = '0;
          mem_req.wdata = w;
          head_nxt      = '0;
          empty_nxt     = 1'b0;
          ready_nxt     = 1'b1;
          committed_nxt = PG_W'(START_PAGES);
        end
        needg_nxt = NEED_W'(((REQ_W+1)'(size_eff) + (REQ_W+1)'(HDR_LEN + 7)) >> 3);
        res_nxt.payload_address = '0;
        res_nxt.status          = RS_OK;
        if (req_r.request_size == '0) begin
          res_nxt.status = RS_IGNORED;
          state_nxt      = S_DONE;
        end else if (!(ready_r || init_ok)) begin
          res_nxt.status = RS_NOMEM;
          state_nxt      = S_DONE;
        end else if (!init_ok && empty_r) begin
          state_nxt = S_A_GROW;
        end else begin
          state_nxt = S_A_RDH;
        end
      end

      S_A_RDH: begin
        mem_req.addr = head_r;
        cur_nxt      = head_r;
        state_nxt    = S_A_WALK;
      end

      // One free-list node per cycle: the next read is issued as soon as the
      // current header arrives.
      S_A_WALK: begin
        h_nxt = mem_rdata;
        if (mem_rdata.is_free && (NEED_W'(mem_rdata.size) >= needg_r)) begin
          state_nxt = S_A_CLAIM;
        end else if (!mem_rdata.has_next) begin
          state_nxt = S_A_GROW;
        end else begin
          cur_nxt      = mem_rdata.next;
          mem_req.addr = mem_rdata.next;
        end
      end

      S_A_GROW: begin
        if (!grow_ok) begin
          res_nxt.status = RS_NOMEM;
          state_nxt      = S_DONE;
        end else begin
          committed_nxt = PG_W'(total);
          if (!empty_r && h_r.is_free &&
              ((IDX_W+2)'(cur_r) + (IDX_W+2)'(h_r.size) == (IDX_W+2)'(gnew))) begin
            h_nxt.size = h_r.size + ext;
            state_nxt  = S_A_CLAIM;
          end else begin
            w.size        = ext;
            w.taken       = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = gnew;
            mem_req.wdata = w;
            res_nxt.payload_address = addr_of(gnew);
            state_nxt     = S_DONE;
          end
        end
      end

      S_A_CLAIM: begin
        split_nxt     = split;
        ng_nxt        = cur_r + IDX_W'(needg_r);
        w.size        = split ? SZ_W'(needg_r) : h_r.size;
        w.taken       = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = cur_r;
        mem_req.wdata = w;
        res_nxt.payload_address = addr_of(cur_r);
        state_nxt     = split ? S_A_CL2 : S_A_CL3;
      end

      // The split-off tail takes the claimed block's place in the list.
      S_A_CL2: begin
        w             = h_r;
        w.size        = h_r.size - SZ_W'(needg_r);
        w.is_free     = 1'b1;
        w.taken       = 1'b0;
        mem_req.we    = 1'b1;
        mem_req.addr  = ng_r;
        mem_req.wdata = w;
        state_nxt     = S_A_CL3;
      end

      S_A_CL3: begin
        if (h_r.has_prev) begin
          do_patch = 1'b1;
          pt_addr  = h_r.prev;
          pt_val   = rnext;
          pt_has   = rhas;
          pt_ret   = S_A_CL4;
        end else begin
          head_nxt  = rnext;
          empty_nxt = !rhas;
          state_nxt = S_A_CL4;
        end
      end

      S_A_CL4: begin
        if (h_r.has_next) begin
          do_patch = 1'b1;
          pt_prev  = 1'b1;
          pt_addr  = h_r.next;
          pt_val   = split_r ? ng_r : h_r.prev;
          pt_has   = split_r | h_r.has_prev;
          pt_ret   = S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_F_START: begin
        res_nxt.payload_address = '0;
        res_nxt.status          = RS_OK;
        g_nxt = off[IDX_W+2:3];
        if (req_r.free_address == '0) begin
          res_nxt.status = RS_IGNORED;
          state_nxt      = S_DONE;
        end else if (!ready_r || req_r.free_address < (ORIGIN + ADDR_W'(HDR_LEN)) ||
                     off[2:0] != 3'd0 ||
                     off >= (ADDR_W'(committed_r) << PAGE_BSH) ||
                     off >= ADDR_W'(HEAP_BYTES)) begin
          res_nxt.status = RS_BADFREE;
          state_nxt      = S_DONE;
        end else begin
          mem_req.addr = off[IDX_W+2:3];
          state_nxt    = S_F_HDR;
        end
      end

      S_F_HDR: begin
        if (!mem_rdata.taken) begin
          res_nxt.status = RS_BADFREE;
          state_nxt      = S_DONE;
        end else begin
          h_nxt         = mem_rdata;
          h_nxt.is_free = 1'b1;
          h_nxt.taken   = 1'b0;
          if (empty_r || g_r < head_r) begin
            h_nxt.has_next = !empty_r;
            h_nxt.next     = empty_r ? '0 : head_r;
            h_nxt.has_prev = 1'b0;
            h_nxt.prev     = '0;
            head_nxt       = g_r;
            empty_nxt      = 1'b0;
            if (!empty_r) begin
              do_patch = 1'b1;
              pt_prev  = 1'b1;
              pt_addr  = head_r;
              pt_val   = g_r;
              pt_has   = 1'b1;
              pt_ret   = S_F_NX;
            end else begin
              state_nxt = S_F_NX;
            end
          end else begin
            cur_nxt      = head_r;
            mem_req.addr = head_r;
            state_nxt    = S_F_WALK;
          end
        end
      end

      S_F_WALK: begin
        if (mem_rdata.has_next && mem_rdata.next < g_r) begin
          cur_nxt      = mem_rdata.next;
          mem_req.addr = mem_rdata.next;
        end else begin
          h_nxt.has_next = mem_rdata.has_next;
          h_nxt.next     = mem_rdata.next;
          h_nxt.has_prev = 1'b1;
          h_nxt.prev     = cur_r;
          w              = mem_rdata;
          w.next         = g_r;
          w.has_next     = 1'b1;
          mem_req.we     = 1'b1;
          mem_req.addr   = cur_r;
          mem_req.wdata  = w;
          if (mem_rdata.has_next) begin
            do_patch = 1'b1;
            pt_prev  = 1'b1;
            pt_addr  = mem_rdata.next;
            pt_val   = g_r;
            pt_has   = 1'b1;
            pt_ret   = S_F_NX;
          end else begin
            state_nxt = S_F_NX;
          end
        end
      end

      S_F_NX: begin
        if (h_r.has_next &&
            ((IDX_W+2)'(h_r.next) == (IDX_W+2)'(g_r) + (IDX_W+2)'(h_r.size))) begin
          mem_req.addr = h_r.next;
          state_nxt    = S_F_NXD;
        end else begin
          state_nxt = S_F_PV;
        end
      end

      // Merge with the following free block; it leaves the list but keeps
      // its free flag.
      S_F_NXD: begin
        state_nxt = S_F_PV;
        if (mem_rdata.is_free) begin
          h_nxt.size     = h_r.size + mem_rdata.size;
          h_nxt.next     = mem_rdata.next;
          h_nxt.has_next = mem_rdata.has_next;
          w              = mem_rdata;
          w.has_next     = 1'b0;
          w.has_prev     = 1'b0;
          w.next         = '0;
          w.prev         = '0;
          mem_req.we     = 1'b1;
          mem_req.addr   = h_r.next;
          mem_req.wdata  = w;
          if (mem_rdata.has_next) begin
            do_patch = 1'b1;
            pt_prev  = 1'b1;
            pt_addr  = mem_rdata.next;
            pt_val   = mem_rdata.prev;
            pt_has   = mem_rdata.has_prev;
            pt_ret   = S_F_PV;
          end
        end
      end

      S_F_PV: begin
        if (h_r.has_prev) begin
          mem_req.addr = h_r.prev;
          state_nxt    = S_F_PVD;
        end else begin
          state_nxt = S_F_WH;
        end
      end

      // Merge into the preceding free block, which absorbs this one's size.
      S_F_PVD: begin
        state_nxt = S_F_WH;
        if (mem_rdata.is_free &&
            ((IDX_W+2)'(h_r.prev) + (IDX_W+2)'(mem_rdata.size) == (IDX_W+2)'(g_r))) begin
          w              = mem_rdata;
          w.next         = h_r.next;
          w.has_next     = h_r.has_next;
          w.size         = mem_rdata.size + h_r.size;
          mem_req.we     = 1'b1;
          mem_req.addr   = h_r.prev;
          mem_req.wdata  = w;
          h_nxt.has_next = 1'b0;
          h_nxt.has_prev = 1'b0;
          h_nxt.next     = '0;
          h_nxt.prev     = '0;
          if (h_r.has_next) begin
            do_patch = 1'b1;
            pt_prev  = 1'b1;
            pt_addr  = h_r.next;
            pt_val   = h_r.prev;
            pt_has   = h_r.has_prev;
            pt_ret   = S_F_WH;
          end
        end
      end

      S_F_WH: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = g_r;
        mem_req.wdata = h_r;
        state_nxt     = S_DONE;
      end

      // Link patch: read a neighbor header, rewrite one of its links.
      S_PT_RD: begin
        mem_req.addr = pa_r;
        state_nxt    = S_PT_WR;
      end

      S_PT_WR: begin
        w = mem_rdata;
        if (pprev_r) begin
          w.prev     = pv_r;
          w.has_prev = ph_r;
        end else begin
          w.next     = pv_r;
          w.has_next = ph_r;
        end
        mem_req.we    = 1'b1;
        mem_req.addr  = pa_r;
        mem_req.wdata = w;
        state_nxt     = ret_r;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_patch) begin
      pa_nxt    = pt_addr;
      pv_nxt    = pt_val;
      pprev_nxt = pt_prev;
      ph_nxt    = pt_has;
      ret_nxt   = pt_ret;
      state_nxt = S_PT_RD;
    end
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE) && res_take;
  assign res       = res_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (committed_r != $past(committed_r)) |-> ($past(state_r) != S_IDLE))
    else $error("page count changed while no transaction was in progress");

  assert property (@(posedge clk) disable iff (!rst_n)
    !ready_r |-> empty_r)
    else $error("free list holds blocks before the heap was started");

  assert property (@(posedge clk) disable iff (!rst_n)
    (stat.done && !req_r.mode && res_r.status == RS_OK) |-> (res_r.payload_address != '0))
    else $error("successful allocation returned a null address");

  assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("transaction started while the sequencer was busy");

endmodule

/* hdl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: handshakes, page limit register,
// result register and header RAM. Depends on ffha_pkg, ffha_ram and ffha_ctrl.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_stall  ffha_pkg::in_item_t (mode, size, address)
//   out_      output     out_valid/out_stall ffha_pkg::out_item_t (address, status)
//   cfg_      input      cfg_wr_en          page_limit, 9 bits
//
// A transaction is accepted in the idle state; its run time grows with each
// free-list node visited, and each neighbor link update adds a header read
// and a header write. The run time is set by the single port of the
// header RAM, which every list step goes through.
// Reset is synchronous and active low; the header RAM is not cleared, and a free
// aimed at a granule whose header was never written reads an uninitialized entry.
// A result waits in the output register while out_stall is high, and the next
// request can already be accepted and worked on in the meantime.
module first_fit_heap_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ffha_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ffha_pkg::out_item_t        out_item,
  input  logic                       cfg_wr_en,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_wr_data
);
  import ffha_pkg::*;

  logic [CFG_W-1:0] page_limit_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  ctrl_stat_t       stat;
  out_item_t        res;
  mem_req_t         mem_req;
  logic [HDR_W-1:0] ram_rdata;
  logic             start;
  logic             res_take;

  // The sequencer holds one request at a time; it accepts a new transaction
  // only from its idle state, which does not depend on in_valid.
  assign in_stall = !stat.idle;
  assign start    = in_valid && stat.idle;

  // The sequencer may hand over its result whenever the output register is
  // empty or being emptied in this cycle.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        page_limit_r <= cfg_wr_data;
      end
      if (stat.done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  ffha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req        (in_item),
    .page_limit (page_limit_r),
    .res_take   (res_take),
    .stat       (stat),
    .res        (res),
    .mem_req    (mem_req),
    .mem_rdata  (ram_rdata)
  );

  // One header per 8-byte granule of the heap.
  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HDR_DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (ram_rdata)
  );

endmodule

/* dv/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for first_fit_heap_allocator: a heap model predicts each
// result; random and directed allocate/free traffic under varied stalls and page limits.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL only.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned ORIGIN_BASE = 32'h0200_0000;
  localparam int unsigned START_SPAN  = 32'h10000;
  localparam int unsigned MARK_VACANT = 32'hF4EE;
  localparam int unsigned MARK_TAKEN  = 32'h1CED;
  localparam int unsigned HDR_BYTES   = 16;
  localparam int unsigned SPARE_BYTES = 24;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam int CYCLE_LIMIT  = 8_000_000;

  // Heap model plus the queue of results it has predicted but not yet seen.
  class heap_scoreboard;
    int unsigned bsize [HDR_DEPTH];
    int unsigned bmark [HDR_DEPTH];
    bit          bfree [HDR_DEPTH];
    bit          bhas_next [HDR_DEPTH];
    bit          bhas_prev [HDR_DEPTH];
    int unsigned bnext [HDR_DEPTH];
    int unsigned bprev [HDR_DEPTH];
    bit          touched [HDR_DEPTH];
    int unsigned touched_list[$];
    int unsigned live_addrs[$];
    int unsigned list_head;
    bit          list_empty;
    int unsigned pages;
    bit          ready;
    int unsigned limit;
    out_item_t   awaited[$];
    int          errors;

    function new();
      list_head = 0; list_empty = 1; pages = 0; ready = 0; limit = 256; errors = 0;
    endfunction

    function int unsigned gi(int unsigned g);
      return (g < HDR_DEPTH) ? g : 0;
    endfunction

    function void touch(int unsigned g);
      if (!touched[g]) begin
        touched[g] = 1;
        touched_list.push_back(g);
      end
    endfunction

    function void unlink(int unsigned g);
      int unsigned p, n;
      p = bprev[g];
      n = bnext[g];
      if (bhas_prev[g]) begin
        bnext[gi(p)] = n;
        bhas_next[gi(p)] = bhas_next[g];
      end else begin
        list_head = n;
        list_empty = !bhas_next[g];
      end
      if (bhas_next[g]) begin
        bprev[gi(n)] = p;
        bhas_prev[gi(n)] = bhas_prev[g];
      end
      bhas_next[g] = 0; bhas_prev[g] = 0; bnext[g] = 0; bprev[g] = 0;
    endfunction

    // Keeps the free list in address order.
    function void put_sorted(int unsigned g);
      int unsigned cur, cnt;
      cnt = 0;
      bmark[g] = MARK_VACANT;
      bfree[g] = 1;
      if (list_empty || g < list_head) begin
        bhas_next[g] = !list_empty;
        bnext[g] = list_empty ? 0 : list_head;
        bhas_prev[g] = 0; bprev[g] = 0;
        if (!list_empty) begin
          bprev[gi(list_head)] = g;
          bhas_prev[gi(list_head)] = 1;
        end
        list_head = g;
        list_empty = 0;
        return;
      end
      cur = list_head;
      while (bhas_next[gi(cur)] && bnext[gi(cur)] < g && cnt < HDR_DEPTH) begin
        cur = bnext[gi(cur)];
        cnt++;
      end
      cur = gi(cur);
      bhas_next[g] = bhas_next[cur];
      bnext[g] = bnext[cur];
      bhas_prev[g] = 1; bprev[g] = cur;
      if (bhas_next[cur]) begin
        bprev[gi(bnext[cur])] = g;
        bhas_prev[gi(bnext[cur])] = 1;
      end
      bnext[cur] = g;
      bhas_next[cur] = 1;
    endfunction

    // Takes a free block, splitting off the tail when enough would be left.
    function void take(int unsigned g, int unsigned need);
      int unsigned ng;
      if (bsize[g] >= need + SPARE_BYTES) begin
        ng = gi(g + need / GRAN_BYTES);
        touch(ng);
        bsize[ng] = bsize[g] - need;
        bmark[ng] = MARK_VACANT;
        bfree[ng] = 1;
        unlink(g);
        bsize[g] = need;
        put_sorted(ng);
        put_sorted(g);
      end
      unlink(g);
      bmark[g] = MARK_TAKEN;
      bfree[g] = 0;
    endfunction

    function bit grow(int unsigned more);
      int unsigned total;
      total = pages + more;
      if (total > limit || total > MAX_PAGES) return 0;
      pages = total;
      return 1;
    endfunction

    function int unsigned addr_at(int unsigned g);
      return (ORIGIN_BASE + g * GRAN_BYTES + HDR_BYTES) & 32'h3FF_FFFF;
    endfunction

    function void remove_live(int unsigned a);
      foreach (live_addrs[i]) begin
        if (live_addrs[i] == a) begin
          live_addrs.delete(i);
          return;
        end
      end
    endfunction

    function out_item_t allocate(int unsigned req);
      out_item_t r;
      int unsigned need, npg, ext, old, g, last;
      r.payload_address = '0;
      r.status = RS_OK;
      if (!ready && grow(START_SPAN / PAGE_BYTES)) begin
        touch(0);
        bsize[0] = START_SPAN; bmark[0] = MARK_VACANT; bfree[0] = 1;
        bhas_next[0] = 0; bhas_prev[0] = 0; bnext[0] = 0; bprev[0] = 0;
        list_head = 0; list_empty = 0; ready = 1;
      end
      if (req == 0) begin
        r.status = RS_IGNORED;
        return r;
      end
      if (!ready) begin
        r.status = RS_NOMEM;
        return r;
      end
      if (req < 8) req = 8;
      need = (HDR_BYTES + req + GRAN_BYTES - 1) & ~(GRAN_BYTES - 1);
      if (!list_empty) begin
        g = list_head;
        for (int n = 0; n < HDR_DEPTH; n++) begin
          if (bfree[gi(g)] && bsize[gi(g)] >= need) begin
            take(gi(g), need);
            r.payload_address = addr_at(g);
            return r;
          end
          if (!bhas_next[gi(g)]) break;
          g = bnext[gi(g)];
        end
      end
      npg = (need + PAGE_BYTES - 1) / PAGE_BYTES;
      if (npg < 1) npg = 1;
      ext = npg * PAGE_BYTES;
      old = pages;
      if (!grow(npg)) begin
        r.status = RS_NOMEM;
        return r;
      end
      g = old * (PAGE_BYTES / GRAN_BYTES);
      if (!list_empty) begin
        last = list_head;
        for (int n = 0; n < HDR_DEPTH && bhas_next[gi(last)]; n++) last = bnext[gi(last)];
        last = gi(last);
        if (last + bsize[last] / GRAN_BYTES == g && bfree[last]) begin
          bsize[last] += ext;
          take(last, need);
          r.payload_address = addr_at(last);
          return r;
        end
      end
      g = gi(g);
      touch(g);
      bsize[g] = ext; bmark[g] = MARK_TAKEN; bfree[g] = 0;
      bhas_next[g] = 0; bhas_prev[g] = 0; bnext[g] = 0; bprev[g] = 0;
      r.payload_address = addr_at(g);
      return r;
    endfunction

    function out_item_t release_block(int unsigned a);
      out_item_t r;
      int unsigned off, g, nx, p;
      r.payload_address = '0;
      r.status = RS_OK;
      if (a == 0) begin
        r.status = RS_IGNORED;
        return r;
      end
      if (!ready || a < ORIGIN_BASE + HDR_BYTES) begin
        r.status = RS_BADFREE;
        return r;
      end
      off = a - ORIGIN_BASE - HDR_BYTES;
      if ((off % GRAN_BYTES) != 0 || off >= pages * PAGE_BYTES || off >= HEAP_BYTES) begin
        r.status = RS_BADFREE;
        return r;
      end
      g = off / GRAN_BYTES;
      if (bmark[g] != MARK_TAKEN) begin
        r.status = RS_BADFREE;
        return r;
      end
      put_sorted(g);
      if (bhas_next[g] && bnext[g] == g + bsize[g] / GRAN_BYTES && bfree[gi(bnext[g])]) begin
        nx = gi(bnext[g]);
        unlink(nx);
        bsize[g] += bsize[nx];
      end
      if (bhas_prev[g]) begin
        p = gi(bprev[g]);
        if (p + bsize[p] / GRAN_BYTES == g && bfree[p]) begin
          unlink(g);
          bsize[p] += bsize[g];
        end
      end
      return r;
    endfunction

    // Notes one accepted request and queues the result it must produce.
    function void note_request(in_item_t it);
      out_item_t r;
      if (it.mode == MODE_ALLOC) begin
        r = allocate(it.request_size);
        if (r.status == RS_OK) live_addrs.push_back(r.payload_address);
      end else begin
        r = release_block(it.free_address);
        if (r.status == RS_OK) remove_live(it.free_address);
      end
      awaited.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(out_item_t got);
      out_item_t exp_r;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result addr=%h status=%0d",
                         got.payload_address, got.status));
        return;
      end
      exp_r = awaited.pop_front();
      if (got.payload_address !== exp_r.payload_address)
        report($sformatf("payload_address %h, predicted %h",
                         got.payload_address, exp_r.payload_address));
      if (got.status !== exp_r.status)
        report($sformatf("status %0d, predicted %0d", got.status, exp_r.status));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;

  heap_scoreboard sb;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  cycles;

  first_fit_heap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check every accepted transaction, then pick the next stall value.
  // Values read here are those from before this edge, so the order of processes
  // within the step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
  end

  // Offers one transaction and holds it until accepted. An optional gap goes first;
  // without one, valid stays high and only the payload changes.
  task automatic send_request(in_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic alloc_req(int unsigned req);
    in_item_t it;
    it.mode = MODE_ALLOC;
    it.request_size = req[REQ_W-1:0];
    it.free_address = ADDR_W'($urandom);
    send_request(it);
  endtask

  task automatic free_req(int unsigned a);
    in_item_t it;
    it.mode = MODE_FREE;
    it.request_size = REQ_W'($urandom);
    it.free_address = a[ADDR_W-1:0];
    send_request(it);
  endtask

  // Register writes happen only with nothing in flight; the sender holds off until
  // every predicted result is back and the block has had time to settle.
  task automatic set_page_limit(int unsigned v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.limit = v;
  endtask

  // One random transaction. Most frees target live blocks so that splitting and
  // coalescing get real exercise; the rest are null, misaligned, out-of-range,
  // or aimed at headers that already exist (double frees). Headers never written
  // are never targeted.
  task automatic random_request();
    int unsigned pick, a, top;
    pick = $urandom_range(99);
    if (pick < 55 || (sb.live_addrs.size() == 0 && pick < 80)) begin
      pick = $urandom_range(99);
      if (pick < 65)      alloc_req($urandom_range(1, 64));
      else if (pick < 80) alloc_req($urandom_range(65, 512));
      else if (pick < 88) alloc_req($urandom_range(513, 6000));
      else if (pick < 92) alloc_req($urandom_range(0, 7));
      else if (pick < 95) alloc_req(0);
      else if (pick < 97) alloc_req($urandom_range(6001, 40000));
      else                alloc_req($urandom & 24'hFF_FFFF);
    end else begin
      pick = $urandom_range(99);
      top = ORIGIN_BASE + HDR_BYTES + sb.pages * PAGE_BYTES;
      if (pick < 75 && sb.live_addrs.size() != 0) begin
        free_req(sb.live_addrs[$urandom_range(sb.live_addrs.size() - 1)]);
      end else if (pick < 85 && sb.touched_list.size() != 0) begin
        a = sb.touched_list[$urandom_range(sb.touched_list.size() - 1)];
        free_req(sb.addr_at(a));
      end else if (pick < 89) begin
        free_req(0);
      end else if (pick < 93 && sb.live_addrs.size() != 0) begin
        free_req(sb.live_addrs[$urandom_range(sb.live_addrs.size() - 1)]
                 + $urandom_range(1, 7));
      end else if (pick < 96) begin
        free_req($urandom_range(1, ORIGIN_BASE + HDR_BYTES - 1));
      end else begin
        free_req($urandom_range(top, 32'h3FF_FFFF));
      end
    end
  endtask

  task automatic random_phase(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) random_request();
  endtask

  initial begin
    in_item_t it;
    int unsigned a;
    sb = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With a page limit of zero the lazy start cannot commit anything.
    set_page_limit(0);
    alloc_req(0);
    alloc_req(5);
    free_req(ORIGIN_BASE + HDR_BYTES);
    free_req(0);

    // Normal heap: lazy start, small sizes, reuse, and every kind of bad free.
    set_page_limit(256);
    alloc_req(0);
    alloc_req(1);
    alloc_req(8);
    alloc_req(100);
    a = sb.live_addrs[0];
    alloc_req(24);
    free_req(a);
    free_req(a);
    free_req(a + 3);
    free_req(ORIGIN_BASE + HDR_BYTES - 8);
    free_req(32'h3FF_FFFF);
    free_req(ORIGIN_BASE + HDR_BYTES + START_SPAN);
    alloc_req(70000);
    alloc_req(24'hFF_FFFF);
    free_req(sb.live_addrs[1]);
    free_req(sb.live_addrs[1]);
    free_req(sb.live_addrs[0]);
    it.mode = MODE_FREE;
    it.request_size = '1;
    it.free_address = '1;
    send_request(it);

    // Widest register value, then a tight limit so growth runs out, then normal.
    set_page_limit(511);
    random_phase(370, 33, 50);
    set_page_limit($urandom_range(30, 48));
    random_phase(370, 50, 33);
    set_page_limit(256);
    random_phase(370, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
